>>> src/ucd_pkg.sv
// Package: shared constants and item types of the undirected cycle detector.
`default_nettype none

package ucd_pkg;

    // Graph sizes.
    localparam int MAX_VERTICES = 256;
    localparam int VERT_W       = $clog2(MAX_VERTICES);
    localparam int CNT_VW       = VERT_W + 1;
    localparam int MAX_EDGES    = 1024;
    localparam int ENTRY_CAP    = 2 * MAX_EDGES;
    localparam int ENTRY_W      = $clog2(ENTRY_CAP);
    localparam int USED_W       = ENTRY_W + 1;

    // Action codes.
    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_QUERY = 2'd1,
        ACT_CLEAR = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    // One input item.
    typedef struct packed {
        logic [1:0]        action;
        logic [VERT_W-1:0] end_a;
        logic [VERT_W-1:0] end_b;
    } cmd_t;

    // One result item.
    typedef struct packed {
        logic is_answer;
        logic has_cycle;
        logic edge_rejected;
    } result_t;

    // One breadth-first queue entry.
    typedef struct packed {
        logic [VERT_W-1:0] vertex;
        logic [VERT_W-1:0] from;
        logic              has_from;
    } queue_entry_t;

endpackage

`default_nettype wire

>>> src/undirected_cycle_detect_bfs_unit.sv
// Top level: adjacency-list store and breadth-first cycle search over RAMs.
//
// Channel  | Signals                 | Handshake
// ---------+-------------------------+-----------------------------------------
// command  | start, busy, cmd        | item taken at clk edge with start & !busy
// result   | done, result            | done high for one cycle, always taken
// config   | cfg_we, cfg_wdata       | vertex_count written when cfg_we is high
//
// An add item makes two list appends through the head/tail RAM, ST_ADD_A then
// ST_ADD_B; a rejected edge, clear or unknown action answers in the next cycle.
// A query clears every visited mark over the whole vertex range, then searches
// from each unvisited vertex below the count; a dequeued vertex with edges has
// its list bounds read, and each adjacency entry walked needs an entry read and a visited lookup.
// Reset is asynchronous; all lists are empty after it, with no clearing pass.
// busy stays high until the result strobe; the receiver cannot stall.
`default_nettype none

module undirected_cycle_detect_bfs_unit (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire ucd_pkg::cmd_t         cmd,
    output logic                       done,
    output ucd_pkg::result_t           result,
    input  wire logic                  cfg_we,
    input  wire logic [ucd_pkg::CNT_VW-1:0] cfg_wdata
);

    localparam int VW = ucd_pkg::VERT_W;
    localparam int EW = ucd_pkg::ENTRY_W;
    localparam int NW = ucd_pkg::CNT_VW;
    localparam int UW = ucd_pkg::USED_W;
    localparam int NV = ucd_pkg::MAX_VERTICES;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b000_0000_0001,
        ST_ADD_A = 11'b000_0000_0010,
        ST_ADD_B = 11'b000_0000_0100,
        ST_CLR   = 11'b000_0000_1000,
        ST_OUTER = 11'b000_0001_0000,
        ST_OUTW  = 11'b000_0010_0000,
        ST_POP   = 11'b000_0100_0000,
        ST_POPW  = 11'b000_1000_0000,
        ST_HEAD  = 11'b001_0000_0000,
        ST_EDGE  = 11'b010_0000_0000,
        ST_EDGEW = 11'b100_0000_0000
    } state_t;

    state_t state_reg, state_next;

    // Control registers.
    logic [UW-1:0] entries_used_reg, entries_used_next;
    logic [NV-1:0] used_reg, used_next;
    logic [NW-1:0] vcount_reg, vcount_next;
    logic [NW-1:0] scan_reg, scan_next;
    logic [NW-1:0] rp_reg, rp_next;
    logic [NW-1:0] wp_reg, wp_next;
    logic          done_reg, done_next;

    // Payload registers.
    ucd_pkg::cmd_t    cmd_reg, cmd_next;
    ucd_pkg::result_t result_reg, result_next;
    logic [VW-1:0]    u_reg, u_next;
    logic [VW-1:0]    par_reg, par_next;
    logic             has_reg, has_next;
    logic [EW-1:0]    edge_reg, edge_next;
    logic [EW-1:0]    tail_reg, tail_next;
    logic [EW-1:0]    fw_head_reg, fw_head_next;
    logic [EW-1:0]    fw_tail_reg, fw_tail_next;

    // RAM ports.
    logic            ht_we;
    logic [VW-1:0]   ht_waddr, ht_raddr;
    logic [2*EW-1:0] ht_wdata, ht_rdata;
    logic            nb_we;
    logic [EW-1:0]   nb_waddr;
    logic [VW-1:0]   nb_wdata, nb_rdata;
    logic            lk_we;
    logic [EW-1:0]   lk_waddr, lk_wdata, lk_rdata;
    logic [EW-1:0]   ent_raddr;
    logic            q_we;
    logic [VW-1:0]   q_waddr, q_raddr;
    ucd_pkg::queue_entry_t q_wdata, q_rdata;
    logic            vs_we;
    logic [VW-1:0]   vs_waddr, vs_raddr;
    logic            vs_wdata, vs_rdata;

    // Helpers.
    logic [NW-1:0] n_eff;
    logic          reject;
    logic [EW-1:0] e_cur;
    logic [EW-1:0] a_head, a_tail, b_head, b_tail;
    logic          a_used, b_used;
    logic [VW-1:0] v_nb;

    // Per-vertex list heads and tails.
    ucd_ram #(.WIDTH(2 * EW), .DEPTH(NV)) u_ht_ram (
        .clk(clk), .we(ht_we), .waddr(ht_waddr), .wdata(ht_wdata),
        .raddr(ht_raddr), .rdata(ht_rdata)
    );

    // Entry neighbours.
    ucd_ram #(.WIDTH(VW), .DEPTH(ucd_pkg::ENTRY_CAP)) u_nb_ram (
        .clk(clk), .we(nb_we), .waddr(nb_waddr), .wdata(nb_wdata),
        .raddr(ent_raddr), .rdata(nb_rdata)
    );

    // Entry links.
    ucd_ram #(.WIDTH(EW), .DEPTH(ucd_pkg::ENTRY_CAP)) u_lk_ram (
        .clk(clk), .we(lk_we), .waddr(lk_waddr), .wdata(lk_wdata),
        .raddr(ent_raddr), .rdata(lk_rdata)
    );

    // Breadth-first queue.
    ucd_ram #(.WIDTH($bits(ucd_pkg::queue_entry_t)), .DEPTH(NV)) u_q_ram (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    // Visited marks, cleared by a pass at the start of each query.
    ucd_ram #(.WIDTH(1), .DEPTH(NV)) u_vs_ram (
        .clk(clk), .we(vs_we), .waddr(vs_waddr), .wdata(vs_wdata),
        .raddr(vs_raddr), .rdata(vs_rdata)
    );

    // Effective vertex count and the edge admission check.
    assign n_eff  = (vcount_reg > NW'(NV)) ? NW'(NV) : vcount_reg;
    assign reject = ({1'b0, cmd.end_a} >= n_eff) || ({1'b0, cmd.end_b} >= n_eff)
                    || (entries_used_reg > UW'(ucd_pkg::ENTRY_CAP - 2));
    assign e_cur  = entries_used_reg[EW-1:0];

    // Head and tail of the endpoint lists, forwarded when both ends match.
    assign a_head = ht_rdata[2*EW-1:EW];
    assign a_tail = ht_rdata[EW-1:0];
    assign a_used = used_reg[cmd_reg.end_a];
    assign b_head = (cmd_reg.end_a == cmd_reg.end_b) ? fw_head_reg : ht_rdata[2*EW-1:EW];
    assign b_tail = (cmd_reg.end_a == cmd_reg.end_b) ? fw_tail_reg : ht_rdata[EW-1:0];
    assign b_used = used_reg[cmd_reg.end_b];
    assign v_nb   = nb_rdata;

    // Sequencer.
    always_comb
    begin
        state_next        = state_reg;
        entries_used_next = entries_used_reg;
        used_next         = used_reg;
        vcount_next       = cfg_we ? cfg_wdata : vcount_reg;
        scan_next         = scan_reg;
        rp_next           = rp_reg;
        wp_next           = wp_reg;
        done_next         = 1'b0;
        cmd_next          = cmd_reg;
        result_next       = result_reg;
        u_next            = u_reg;
        par_next          = par_reg;
        has_next          = has_reg;
        edge_next         = edge_reg;
        tail_next         = tail_reg;
        fw_head_next      = fw_head_reg;
        fw_tail_next      = fw_tail_reg;

        ht_we     = 1'b0;
        ht_waddr  = cmd_reg.end_a;
        ht_wdata  = {a_head, a_tail};
        ht_raddr  = cmd.end_a;
        nb_we     = 1'b0;
        nb_waddr  = e_cur;
        nb_wdata  = cmd_reg.end_b;
        lk_we     = 1'b0;
        lk_waddr  = a_tail;
        lk_wdata  = e_cur;
        ent_raddr = edge_reg;
        q_we      = 1'b0;
        q_waddr   = wp_reg[VW-1:0];
        q_wdata   = '{vertex: v_nb, from: u_reg, has_from: 1'b1};
        q_raddr   = rp_reg[VW-1:0];
        vs_we     = 1'b0;
        vs_waddr  = v_nb;
        vs_wdata  = 1'b1;
        vs_raddr  = v_nb;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd_next    = cmd;
                    result_next = '0;
                    case (cmd.action)
                        ucd_pkg::ACT_ADD:
                        begin
                            if (reject)
                            begin
                                result_next.edge_rejected = 1'b1;
                                done_next                 = 1'b1;
                            end
                            else
                            begin
                                state_next = ST_ADD_A;
                            end
                        end
                        ucd_pkg::ACT_QUERY:
                        begin
                            result_next.is_answer = 1'b1;
                            scan_next             = '0;
                            state_next            = ST_CLR;
                        end
                        ucd_pkg::ACT_CLEAR:
                        begin
                            used_next         = '0;
                            entries_used_next = '0;
                            done_next         = 1'b1;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                        end
                    endcase
                end
            end

            // Append end_b to the list of end_a.
            ST_ADD_A:
            begin
                nb_we    = 1'b1;
                nb_wdata = cmd_reg.end_b;
                lk_we    = a_used;
                lk_waddr = a_tail;
                ht_we    = 1'b1;
                ht_waddr = cmd_reg.end_a;
                ht_wdata = {(a_used ? a_head : e_cur), e_cur};
                fw_head_next = a_used ? a_head : e_cur;
                fw_tail_next = e_cur;
                used_next[cmd_reg.end_a] = 1'b1;
                entries_used_next = entries_used_reg + UW'(1);
                ht_raddr   = cmd_reg.end_b;
                state_next = ST_ADD_B;
            end

            // Append end_a to the list of end_b.
            ST_ADD_B:
            begin
                nb_we    = 1'b1;
                nb_wdata = cmd_reg.end_a;
                lk_we    = b_used;
                lk_waddr = b_tail;
                ht_we    = 1'b1;
                ht_waddr = cmd_reg.end_b;
                ht_wdata = {(b_used ? b_head : e_cur), e_cur};
                used_next[cmd_reg.end_b] = 1'b1;
                entries_used_next = entries_used_reg + UW'(1);
                done_next  = 1'b1;
                state_next = ST_IDLE;
            end

            // Clear one visited mark per cycle over the whole vertex range.
            ST_CLR:
            begin
                vs_we    = 1'b1;
                vs_waddr = scan_reg[VW-1:0];
                vs_wdata = 1'b0;
                if (scan_reg == NW'(NV - 1))
                begin
                    scan_next  = '0;
                    state_next = ST_OUTER;
                end
                else
                begin
                    scan_next = scan_reg + NW'(1);
                end
            end

            // Look up the visited mark of the next source candidate.
            ST_OUTER:
            begin
                if (scan_reg >= n_eff)
                begin
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else
                begin
                    vs_raddr   = scan_reg[VW-1:0];
                    state_next = ST_OUTW;
                end
            end

            // Mark arrives; start a search from the vertex if it is unvisited.
            ST_OUTW:
            begin
                scan_next = scan_reg + NW'(1);
                if (vs_rdata)
                begin
                    state_next = ST_OUTER;
                end
                else
                begin
                    q_we     = 1'b1;
                    q_waddr  = '0;
                    q_wdata  = '{vertex: scan_reg[VW-1:0], from: '0, has_from: 1'b0};
                    vs_we    = 1'b1;
                    vs_waddr = scan_reg[VW-1:0];
                    vs_wdata = 1'b1;
                    rp_next    = '0;
                    wp_next    = NW'(1);
                    state_next = ST_POP;
                end
            end

            // Dequeue one vertex.
            ST_POP:
            begin
                if (rp_reg < wp_reg)
                begin
                    q_raddr    = rp_reg[VW-1:0];
                    rp_next    = rp_reg + NW'(1);
                    state_next = ST_POPW;
                end
                else
                begin
                    state_next = ST_OUTER;
                end
            end

            // Queue entry arrives; fetch its list bounds.
            ST_POPW:
            begin
                u_next   = q_rdata.vertex;
                par_next = q_rdata.from;
                has_next = q_rdata.has_from;
                ht_raddr = q_rdata.vertex;
                state_next = used_reg[q_rdata.vertex] ? ST_HEAD : ST_POP;
            end

            // List bounds arrive; fetch the first entry.
            ST_HEAD:
            begin
                edge_next  = a_head;
                tail_next  = a_tail;
                ent_raddr  = a_head;
                state_next = ST_EDGE;
            end

            // Neighbour arrives; look up its visited mark.
            ST_EDGE:
            begin
                vs_raddr   = v_nb;
                state_next = ST_EDGEW;
            end

            // Examine the neighbour and move along the list.
            ST_EDGEW:
            begin
                if (!vs_rdata)
                begin
                    vs_we    = 1'b1;
                    vs_waddr = v_nb;
                    vs_wdata = 1'b1;
                    if (!wp_reg[NW-1])
                    begin
                        q_we    = 1'b1;
                        q_waddr = wp_reg[VW-1:0];
                        wp_next = wp_reg + NW'(1);
                    end
                end
                if (vs_rdata && (!has_reg || (v_nb != par_reg)))
                begin
                    result_next.has_cycle = 1'b1;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
                else if (edge_reg == tail_reg)
                begin
                    state_next = ST_POP;
                end
                else
                begin
                    edge_next  = lk_rdata;
                    ent_raddr  = lk_rdata;
                    state_next = ST_EDGE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            entries_used_reg <= '0;
            used_reg         <= '0;
            vcount_reg       <= NW'(NV);
            scan_reg         <= '0;
            rp_reg           <= '0;
            wp_reg           <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            entries_used_reg <= entries_used_next;
            used_reg         <= used_next;
            vcount_reg       <= vcount_next;
            scan_reg         <= scan_next;
            rp_reg           <= rp_next;
            wp_reg           <= wp_next;
            done_reg         <= done_next;
        end
    end

    // Payload state.
    always_ff @(posedge clk)
    begin
        cmd_reg     <= cmd_next;
        result_reg  <= result_next;
        u_reg       <= u_next;
        par_reg     <= par_next;
        has_reg     <= has_next;
        edge_reg    <= edge_next;
        tail_reg    <= tail_next;
        fw_head_reg <= fw_head_next;
        fw_tail_reg <= fw_tail_next;
    end

    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

    // The result strobe only comes once the sequencer is back at rest.
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while busy");

    // A taken item either starts work or answers in the next cycle.
    a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy || done))
        else $error("item taken without progress");

    // The entry store never fills past its capacity.
    a_store_bound: assert property (@(posedge clk) disable iff (!rst_n)
        entries_used_reg <= UW'(ucd_pkg::ENTRY_CAP))
        else $error("entry store overflow");

    // A query answer never also flags a rejected edge.
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.is_answer && result.edge_rejected))
        else $error("conflicting result flags");

endmodule

`default_nettype wire

>>> src/ucd_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module ucd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write first port, read second port; a same-address read returns old data.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> dv/ucd_checker.sv
// Checker: predicts cycle-detector results from accepted items and compares them.
module ucd_checker (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          start,
    input  wire logic                          busy,
    input  wire ucd_pkg::cmd_t                 cmd,
    input  wire logic                          done,
    input  wire ucd_pkg::result_t              result,
    input  wire logic                          cfg_we,
    input  wire logic [ucd_pkg::CNT_VW-1:0]    cfg_wdata,
    output int                                 fail_count,
    output int                                 pending_count,
    output int                                 answer_count,
    output int                                 cycle_count,
    output int                                 reject_count
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NV = ucd_pkg::MAX_VERTICES;

    // Shadow graph: adjacency lists kept as queues of neighbours in append order.
    int unsigned      shadow_count;
    int unsigned      adj_list [NV][$];
    int unsigned      entry_total;
    ucd_pkg::result_t expected_q [$];

    // Breadth-first search over the shadow graph, as the block does it.
    function automatic logic graph_has_cycle();
        logic        seen [NV];
        int unsigned bfs_vert [$];
        int unsigned bfs_par [$];
        bit          bfs_haspar [$];
        int unsigned n;
        int unsigned u;
        int unsigned p;
        bit          hp;
        int unsigned v;
        n = (shadow_count > NV) ? NV : shadow_count;
        foreach (seen[i]) seen[i] = 1'b0;
        for (int s = 0; s < n; s++)
        begin
            if (seen[s]) continue;
            bfs_vert = {s};
            bfs_par = {0};
            bfs_haspar = {1'b0};
            seen[s] = 1'b1;
            // The queue holds at most NV entries per search.
            for (int rd = 0; rd < bfs_vert.size() && rd < NV; rd++)
            begin
                u = bfs_vert[rd];
                p = bfs_par[rd];
                hp = bfs_haspar[rd];
                for (int k = 0; k < adj_list[u].size(); k++)
                begin
                    v = adj_list[u][k];
                    if (!seen[v])
                    begin
                        seen[v] = 1'b1;
                        if (bfs_vert.size() < NV)
                        begin
                            bfs_vert.insert(bfs_vert.size(), v);
                            bfs_par.insert(bfs_par.size(), u);
                            bfs_haspar.insert(bfs_haspar.size(), 1'b1);
                        end
                    end
                    else if (!hp || v != p)
                    begin
                        return 1'b1;
                    end
                end
            end
        end
        return 1'b0;
    endfunction

    // Apply one accepted item to the shadow graph and queue its expected result.
    function automatic void apply_item(ucd_pkg::cmd_t c);
        ucd_pkg::result_t r;
        int unsigned      n;
        r = '0;
        n = (shadow_count > NV) ? NV : shadow_count;
        case (ucd_pkg::action_t'(c.action))
            ucd_pkg::ACT_ADD:
            begin
                if (c.end_a >= n || c.end_b >= n || entry_total + 2 > ucd_pkg::ENTRY_CAP)
                begin
                    r.edge_rejected = 1'b1;
                end
                else
                begin
                    adj_list[c.end_a].insert(adj_list[c.end_a].size(), c.end_b);
                    adj_list[c.end_b].insert(adj_list[c.end_b].size(), c.end_a);
                    entry_total += 2;
                end
            end
            ucd_pkg::ACT_QUERY:
            begin
                r.is_answer = 1'b1;
                r.has_cycle = graph_has_cycle();
            end
            ucd_pkg::ACT_CLEAR:
            begin
                foreach (adj_list[i]) adj_list[i].delete();
                entry_total = 0;
            end
            default:
            begin
            end
        endcase
        expected_q.insert(expected_q.size(), r);
    endfunction

    // Watch the channels at each rising edge.
    always @(posedge clk or negedge rst_n)
    begin
        ucd_pkg::result_t exp_r;
        if (!rst_n)
        begin
            shadow_count = NV;
            foreach (adj_list[i]) adj_list[i].delete();
            entry_total = 0;
            expected_q.delete();
            fail_count <= 0;
            pending_count <= 0;
            answer_count <= 0;
            cycle_count <= 0;
            reject_count <= 0;
        end
        else
        begin
            if (cfg_we) shadow_count = cfg_wdata;
            if (done)
            begin
                if (expected_q.size() == 0)
                begin
                    $display("%0t: unexpected result, expected none, actual %b",
                             $time, result);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (result !== exp_r)
                    begin
                        $display({"%0t: result mismatch, expected ans=%b cyc=%b rej=%b,",
                                  " actual ans=%b cyc=%b rej=%b"},
                                 $time, exp_r.is_answer, exp_r.has_cycle,
                                 exp_r.edge_rejected, result.is_answer,
                                 result.has_cycle, result.edge_rejected);
                        fail_count <= fail_count + 1;
                    end
                    if (exp_r.is_answer) answer_count <= answer_count + 1;
                    if (exp_r.has_cycle) cycle_count <= cycle_count + 1;
                    if (exp_r.edge_rejected) reject_count <= reject_count + 1;
                end
            end
            if (start && !busy) apply_item(cmd);
            pending_count <= expected_q.size();
        end
    end
endmodule

>>> dv/tb_undirected_cycle_detect_bfs_unit.sv
// Testbench top: drives items and configuration into the cycle detector and gives the verdict.
module tb_undirected_cycle_detect_bfs_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 200000;
    localparam int VW = ucd_pkg::VERT_W;
    localparam int NW = ucd_pkg::CNT_VW;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    ucd_pkg::cmd_t      cmd;
    logic               done;
    ucd_pkg::result_t   result;
    logic               cfg_we;
    logic [NW-1:0]      cfg_wdata;
    int                 fail_count;
    int                 pending_count;
    int                 answer_count;
    int                 cycle_count;
    int                 reject_count;
    int                 idle_cycles;
    int                 items_sent;
    bit                 no_gaps;

    undirected_cycle_detect_bfs_unit uut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
    );

    ucd_checker chk (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .cmd(cmd),
        .done(done), .result(result), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .fail_count(fail_count), .pending_count(pending_count),
        .answer_count(answer_count), .cycle_count(cycle_count),
        .reject_count(reject_count)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog: count cycles in which no item and no result is accepted.
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("undirected_cycle_detect_bfs_unit test failed");
                $finish;
            end
        end
    end

    // Send one item: hold start until it is taken, then maybe idle a while.
    // Without an idle burst start stays high for the caller's next step.
    task automatic send_item(ucd_pkg::action_t act, logic [VW-1:0] a,
                             logic [VW-1:0] b);
        int gap;
        start <= 1'b1;
        cmd <= '{action: act, end_a: a, end_b: b};
        do @(posedge clk); while (busy);
        @(negedge clk);
        items_sent++;
        if (!no_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            start <= 1'b0;
            cmd <= ucd_pkg::cmd_t'($urandom);
            repeat (gap) @(negedge clk);
        end
    endtask

    // Wait until all results are in, then set vertex_count while idle.
    task automatic write_count(int unsigned value);
        start <= 1'b0;
        while (pending_count != 0 || busy) @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value[NW-1:0];
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random vertex below a limit, sometimes any vertex value at all.
    function automatic logic [VW-1:0] pick_vertex(int unsigned n);
        if (n == 0 || $urandom_range(0, 19) == 0) return VW'($urandom);
        return VW'($urandom_range(0, (n > 256 ? 256 : n) - 1));
    endfunction

    // Random phase: rounds of a clear, random or tree edges with some random actions and queries, then a query.
    task automatic random_phase(int unsigned n, int unsigned count);
        int unsigned lim;
        int unsigned k;
        int unsigned edges;
        int unsigned roll;
        lim = (n > 256) ? 256 : n;
        k = 0;
        while (k < count)
        begin
            send_item(ucd_pkg::ACT_CLEAR, VW'($urandom), VW'($urandom));
            edges = $urandom_range(0, 12);
            roll = $urandom_range(0, 9);
            for (int j = 1; j <= edges && k < count; j++, k++)
            begin
                if (roll < 5 && lim > 1)
                begin
                    // Random edge among the vertices in use.
                    send_item(ucd_pkg::ACT_ADD, pick_vertex(lim), pick_vertex(lim));
                end
                else if (roll < 7 && lim > 1)
                begin
                    // Tree edge: joins a fresh vertex to an earlier one.
                    send_item(ucd_pkg::ACT_ADD, VW'(j % lim),
                              VW'($urandom_range(0, (j - 1) % lim)));
                end
                else if (roll == 7)
                begin
                    send_item(ucd_pkg::action_t'($urandom_range(0, 3)),
                              pick_vertex(lim), pick_vertex(lim));
                end
                else
                begin
                    send_item(ucd_pkg::ACT_ADD, pick_vertex(lim), pick_vertex(lim));
                    if ($urandom_range(0, 3) == 0) send_item(ucd_pkg::ACT_QUERY, '0, '0);
                end
            end
            send_item(ucd_pkg::ACT_QUERY, VW'($urandom), VW'($urandom));
            k += 2;
        end
    endtask

    initial
    begin
        int unsigned counts [6];
        counts = '{256, 1, 8, 0, 511, 40};
        rst_n = 1'b0;
        start = 1'b0;
        cmd = '0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        items_sent = 0;
        no_gaps = 1'b0;
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed: extremes, every action, self-loop, repeated edge, unknown action.
        send_item(ucd_pkg::ACT_QUERY, '0, '0);
        send_item(ucd_pkg::ACT_ADD, 8'd0, 8'd255);
        send_item(ucd_pkg::ACT_ADD, 8'd255, 8'd1);
        send_item(ucd_pkg::ACT_QUERY, '0, '0);
        send_item(ucd_pkg::ACT_ADD, 8'd7, 8'd7);
        send_item(ucd_pkg::ACT_QUERY, '0, '0);
        send_item(ucd_pkg::ACT_CLEAR, 8'hFF, 8'hFF);
        send_item(ucd_pkg::ACT_ADD, 8'd3, 8'd4);
        send_item(ucd_pkg::ACT_ADD, 8'd4, 8'd3);
        send_item(ucd_pkg::ACT_QUERY, '0, '0);
        send_item(ucd_pkg::ACT_NONE, 8'hAA, 8'h55);
        send_item(ucd_pkg::ACT_CLEAR, '0, '0);
        send_item(ucd_pkg::ACT_ADD, 8'd1, 8'd2);
        send_item(ucd_pkg::ACT_ADD, 8'd2, 8'd3);
        send_item(ucd_pkg::ACT_ADD, 8'd3, 8'd1);
        send_item(ucd_pkg::ACT_QUERY, '0, '0);
        write_count(4);
        send_item(ucd_pkg::ACT_ADD, 8'd4, 8'd0);
        send_item(ucd_pkg::ACT_ADD, 8'd0, 8'd3);
        send_item(ucd_pkg::ACT_QUERY, '0, '0);
        write_count(2);
        send_item(ucd_pkg::ACT_QUERY, '0, '0);
        write_count(0);
        send_item(ucd_pkg::ACT_ADD, 8'd0, 8'd0);
        send_item(ucd_pkg::ACT_QUERY, '0, '0);
        write_count(256);

        // Fill the entry store past capacity: a long chain, then rejects.
        send_item(ucd_pkg::ACT_CLEAR, '0, '0);
        for (int i = 0; i < ucd_pkg::ENTRY_CAP / 2 + 3; i++)
            send_item(ucd_pkg::ACT_ADD, VW'(i % 255), VW'(i % 255 + 1));
        send_item(ucd_pkg::ACT_QUERY, '0, '0);

        // Random phases across several vertex counts.
        foreach (counts[c])
        begin
            write_count(counts[c]);
            random_phase(counts[c], 60);
        end
        no_gaps = 1'b1;
        write_count(256);
        random_phase(256, 100);

        // Drain, then give the verdict.
        start <= 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (20) @(negedge clk);
        $display("Sent %0d items: %0d queries answered, %0d found a cycle, %0d edges rejected.",
                 items_sent, answer_count, cycle_count, reject_count);
        $display("Vertex counts from 0 to 511 were set, with random idle bursts and a final gapless run.");
        if (fail_count == 0 && pending_count == 0)
            $display("undirected_cycle_detect_bfs_unit test passed");
        else
            $display("undirected_cycle_detect_bfs_unit test failed");
        $finish;
    end
endmodule
